FILE: hdl/k_smallest_distinct_key_groups_unit_assert.svh
// Assertion macros for the k smallest distinct key groups unit
`ifndef K_SMALLEST_DISTINCT_KEY_GROUPS_UNIT_ASSERT_SVH
`define K_SMALLEST_DISTINCT_KEY_GROUPS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge out of reset
`define KSDK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ksdk assertion failed");
// Next-cycle implication
`define KSDK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ksdk assertion failed");
`else
`define KSDK_ASSERT_IMP(lbl, ante, cons)
`define KSDK_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/ksdk_pkg.sv
// Types and constants shared by the k smallest distinct key groups unit
package ksdk_pkg;

  localparam int ID_W      = 31;
  localparam int KEY_W     = 16;
  localparam int RANK_W    = 6;
  localparam int GCNT_W    = 7;
  localparam int ENTRY_W   = ID_W + KEY_W + 1;
  localparam int RES_W     = 7;
  localparam int RES_LIMIT = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 2;

  // Register addresses (byte offsets, word aligned)
  localparam logic [ADDR_W-1:0] REG_GROUP_COUNT = 2'd0;

  localparam logic [GCNT_W-1:0] GROUP_COUNT_RST = 7'd1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MIN_RD,
    S_MIN_CMP,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_PUSH,
    S_EMIT_NEXT,
    S_FLUSH
  } state_t;

endpackage

FILE: hdl/k_smallest_distinct_key_groups_unit.sv
// Top level: loads (id, key) entries and reports the groups with the smallest distinct keys
//
// Entries are loaded one item per cycle into an entry memory with one write port and
// one registered read port. The item with load_last set ends the set and starts the
// selection (if group_count is zero the set is dropped instead), and in_stall stays
// high until the selection is done. For each group the sequencer makes two passes
// over the n stored entries through the one read port. The minimum search over
// untaken keys reads each entry (S_MIN_RD) and compares it (S_MIN_CMP). The emit
// pass reads (S_EMIT_RD), checks (S_EMIT_CHK) and steps (S_EMIT_NEXT) each entry,
// and it marks members taken and hands each one to the output through S_PUSH. When
// the set runs out of keys before group_count groups, one more minimum search runs,
// and a stalled output can hold the sequencer in S_PUSH or S_FLUSH. One result is
// held back in a pending register so group_end and run_end can be set on it. The
// group_count register (reset 1) sits at byte address 0 of the APB port.
`include "k_smallest_distinct_key_groups_unit_assert.svh"

module k_smallest_distinct_key_groups_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ksdk_pkg::ID_W-1:0]     in_entry_id,
  input  logic [ksdk_pkg::KEY_W-1:0]    in_entry_key,
  input  logic                          in_load_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ksdk_pkg::RANK_W-1:0]   out_group_rank,
  output logic [ksdk_pkg::KEY_W-1:0]    out_group_key,
  output logic [ksdk_pkg::ID_W-1:0]     out_member_id,
  output logic                          out_group_end,
  output logic                          out_run_end,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ksdk_pkg::ADDR_W-1:0]   paddr,
  input  logic [ksdk_pkg::DATA_W-1:0]   pwdata,
  output logic [ksdk_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int ID_W    = ksdk_pkg::ID_W;
  localparam int KEY_W   = ksdk_pkg::KEY_W;
  localparam int RANK_W  = ksdk_pkg::RANK_W;
  localparam int GCNT_W  = ksdk_pkg::GCNT_W;
  localparam int ENTRY_W = ksdk_pkg::ENTRY_W;
  localparam int RES_W   = ksdk_pkg::RES_W;

  // entry memory: {taken, key, id}
  logic [ENTRY_W-1:0] mem_r [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  ksdk_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [KEY_W-1:0]  best_r, best_nxt;
  logic              found_r, found_nxt;
  logic [GCNT_W-1:0] rank_r, rank_nxt;
  logic [RES_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [ID_W-1:0]   cand_id_r, cand_id_nxt;
  logic [GCNT_W-1:0] group_count_r, group_count_nxt;

  logic              pend_valid_r, pend_valid_nxt;
  logic [RANK_W-1:0] pend_rank_r, pend_rank_nxt;
  logic [KEY_W-1:0]  pend_key_r, pend_key_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic              pend_ge_r, pend_ge_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_ge_r, out_ge_nxt;
  logic              out_re_r, out_re_nxt;

  logic              rd_taken;
  logic [KEY_W-1:0]  rd_key;
  logic [ID_W-1:0]   rd_id;
  logic              last_idx;
  logic              out_free;
  logic              cfg_wr;

  assign rd_taken = rd_data_r[ENTRY_W-1];
  assign rd_key   = rd_data_r[ID_W +: KEY_W];
  assign rd_id    = rd_data_r[ID_W-1:0];
  assign last_idx = (CNT_W'(idx_r) == (cnt_r - CNT_W'(1)));
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite;

  // APB side: the single register is written at address zero and always read back
  assign pready = 1'b1;
  assign prdata = ksdk_pkg::DATA_W'(group_count_r);

  assign in_stall       = (state_r != ksdk_pkg::S_LOAD);
  assign out_valid      = out_valid_r;
  assign out_group_rank = out_rank_r;
  assign out_group_key  = out_key_r;
  assign out_member_id  = out_id_r;
  assign out_group_end  = out_ge_r;
  assign out_run_end    = out_re_r;

  // sequencer: next state, datapath and memory write
  always_comb begin
    logic upd;
    upd             = 1'b0;
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    best_nxt        = best_r;
    found_nxt       = found_r;
    rank_nxt        = rank_r;
    res_cnt_nxt     = res_cnt_r;
    cand_id_nxt     = cand_id_r;
    group_count_nxt = group_count_r;
    pend_valid_nxt  = pend_valid_r;
    pend_rank_nxt   = pend_rank_r;
    pend_key_nxt    = pend_key_r;
    pend_id_nxt     = pend_id_r;
    pend_ge_nxt     = pend_ge_r;
    out_valid_nxt   = out_valid_r;
    out_rank_nxt    = out_rank_r;
    out_key_nxt     = out_key_r;
    out_id_nxt      = out_id_r;
    out_ge_nxt      = out_ge_r;
    out_re_nxt      = out_re_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = rd_data_r;

    // retire the output item once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // register write
    if (cfg_wr && (paddr == ksdk_pkg::REG_GROUP_COUNT)) begin
      group_count_nxt = pwdata[GCNT_W-1:0];
    end

    case (state_r)
      ksdk_pkg::S_LOAD: begin
        if (in_valid) begin
          // store the entry while there is room
          if (cnt_r < CNT_W'(MAX_ENTRIES)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[IDX_W-1:0];
            mem_wdata = {1'b0, in_entry_key, in_entry_id};
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          if (in_load_last) begin
            if (group_count_r == '0) begin
              cnt_nxt = '0;
            end else begin
              state_nxt   = ksdk_pkg::S_MIN_RD;
              idx_nxt     = '0;
              found_nxt   = 1'b0;
              rank_nxt    = '0;
              res_cnt_nxt = '0;
            end
          end
        end
      end
      ksdk_pkg::S_MIN_RD: begin
        state_nxt = ksdk_pkg::S_MIN_CMP;
      end
      ksdk_pkg::S_MIN_CMP: begin
        // keep the smallest untaken key
        upd = !rd_taken && (!found_r || (rd_key < best_r));
        if (upd) begin
          best_nxt  = rd_key;
          found_nxt = 1'b1;
        end
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = (found_r || upd) ? ksdk_pkg::S_EMIT_RD : ksdk_pkg::S_FLUSH;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ksdk_pkg::S_MIN_RD;
        end
      end
      ksdk_pkg::S_EMIT_RD: begin
        state_nxt = ksdk_pkg::S_EMIT_CHK;
      end
      ksdk_pkg::S_EMIT_CHK: begin
        // mark a member taken and hand it over
        if (!rd_taken && (rd_key == best_r)) begin
          mem_we      = 1'b1;
          mem_wdata   = {1'b1, rd_data_r[ENTRY_W-2:0]};
          cand_id_nxt = rd_id;
          state_nxt   = ksdk_pkg::S_PUSH;
        end else begin
          state_nxt = ksdk_pkg::S_EMIT_NEXT;
        end
      end
      ksdk_pkg::S_PUSH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_rank_nxt  = pend_rank_r;
            out_key_nxt   = pend_key_r;
            out_id_nxt    = pend_id_r;
            out_ge_nxt    = pend_ge_r;
            out_re_nxt    = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_rank_nxt  = rank_r[RANK_W-1:0];
          pend_key_nxt   = best_r;
          pend_id_nxt    = cand_id_r;
          pend_ge_nxt    = 1'b0;
          res_cnt_nxt    = res_cnt_r + RES_W'(1);
          state_nxt      = ksdk_pkg::S_EMIT_NEXT;
        end
      end
      ksdk_pkg::S_EMIT_NEXT: begin
        if (res_cnt_r == RES_W'(ksdk_pkg::RES_LIMIT)) begin
          state_nxt = ksdk_pkg::S_FLUSH;
        end else if (last_idx) begin
          // close the group and start the next search
          pend_ge_nxt = 1'b1;
          rank_nxt    = rank_r + GCNT_W'(1);
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          if ((rank_r + GCNT_W'(1)) == group_count_r) begin
            state_nxt = ksdk_pkg::S_FLUSH;
          end else begin
            state_nxt = ksdk_pkg::S_MIN_RD;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ksdk_pkg::S_EMIT_RD;
        end
      end
      ksdk_pkg::S_FLUSH: begin
        // send the held result as the last one and clear the set
        if (!pend_valid_r) begin
          cnt_nxt   = '0;
          state_nxt = ksdk_pkg::S_LOAD;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rank_nxt   = pend_rank_r;
          out_key_nxt    = pend_key_r;
          out_id_nxt     = pend_id_r;
          out_ge_nxt     = 1'b1;
          out_re_nxt     = 1'b1;
          pend_valid_nxt = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = ksdk_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = ksdk_pkg::S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ksdk_pkg::S_LOAD;
      cnt_r         <= '0;
      idx_r         <= '0;
      found_r       <= 1'b0;
      rank_r        <= '0;
      res_cnt_r     <= '0;
      group_count_r <= ksdk_pkg::GROUP_COUNT_RST;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      idx_r         <= idx_nxt;
      found_r       <= found_nxt;
      rank_r        <= rank_nxt;
      res_cnt_r     <= res_cnt_nxt;
      group_count_r <= group_count_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    cand_id_r   <= cand_id_nxt;
    pend_rank_r <= pend_rank_nxt;
    pend_key_r  <= pend_key_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_ge_r   <= pend_ge_nxt;
    out_rank_r  <= out_rank_nxt;
    out_key_r   <= out_key_nxt;
    out_id_r    <= out_id_nxt;
    out_ge_r    <= out_ge_nxt;
    out_re_r    <= out_re_nxt;
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_r[idx_r];
  end

  `KSDK_ASSERT_IMP(a_res_cnt_bound, 1'b1, res_cnt_r <= RES_W'(ksdk_pkg::RES_LIMIT))
  `KSDK_ASSERT_IMP(a_load_no_pend, state_r == ksdk_pkg::S_LOAD, !pend_valid_r)
  `KSDK_ASSERT_IMP(a_pend_rank, pend_valid_r, GCNT_W'(pend_rank_r) < group_count_r)
  `KSDK_ASSERT_IMP(a_run_end_closes, out_valid_r && out_re_r, out_ge_r)
  `KSDK_ASSERT_NXT(a_flush_clears, state_r == ksdk_pkg::S_FLUSH && state_nxt == ksdk_pkg::S_LOAD,
                   cnt_r == '0)

endmodule
